FILE: rtl/pfda_pkg.sv
// ----------------------------------------------------------------------------
// pfda_pkg
// Shared widths, constants and divider handshake types for the PWM
// frequency and duty averager.
// ----------------------------------------------------------------------------
package pfda_pkg;

    localparam int RAW_W   = 32;
    localparam int HIGH_W  = RAW_W + 1;
    localparam int PER_W   = RAW_W + 2;
    localparam int CLK_W   = 30;
    localparam logic [CLK_W-1:0] CLK_RESET = 30'd150000000;

    // Divider geometry: remainder as wide as the largest divisor (the period).
    localparam int REM_W   = PER_W;
    localparam int NUM_W   = 37;
    localparam int STEP_W  = 6;

    // Quotient widths of the two results.
    localparam int FREQ_Q  = 37;
    localparam int DUTY_Q  = 23;
    localparam int PAIRS_W = 10;

    localparam int H100_W  = HIGH_W + 7;
    localparam int IN_TDATA_W  = 2 * RAW_W;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [REM_W-1:0]  rem;
        logic [NUM_W-1:0]  num;
        logic [REM_W-1:0]  div;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: rtl/pfda_div.sv
// ----------------------------------------------------------------------------
// pfda_div
// Shared restoring divider, one quotient bit per cycle. The remainder is
// preloaded with the numerator bits above the quotient, which must be
// smaller than the divisor; the remaining bits shift in MSB first.
// ----------------------------------------------------------------------------
module pfda_div
    import pfda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [REM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quot;
    logic [REM_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  w_trial;
    logic              w_ge;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        w_trial = {1'b0, r_rem, r_num[NUM_W-1]} - {2'b00, r_div};
        w_ge    = ~w_trial[REM_W+1];
        n_rem   = w_ge ? w_trial[REM_W-1:0] : {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Done pulses for one cycle after the final quotient bit.
            r_done <= !i_req.start && r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_rem  <= i_req.rem;
                r_num  <= i_req.num;
                r_div  <= i_req.div;
                r_quot <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

FILE: rtl/pwm_freq_duty_averager_unit.sv
// ----------------------------------------------------------------------------
// pwm_freq_duty_averager_unit
// Averages frequency and duty over runs of captured PWM high/low pairs.
// ----------------------------------------------------------------------------
// Each accepted beat is one raw capture pair. A pair with a nonzero period,
// taken while fewer than MAX_PAIRS pairs are counted, runs two divisions on
// the shared one-bit-per-cycle divider: 37 steps for the frequency and 23 for
// the duty. A skipped pair runs no division. If any pair is counted, the beat
// marked tlast adds two more divisions of the sums by the count (37 and 23
// steps) before its result is loaded into the output register. The divider is
// the only arithmetic loop, and s_axis_tready is high only while the sequencer
// is idle; a result may wait in the output register while the next pair is
// already being worked.
// ----------------------------------------------------------------------------
module pwm_freq_duty_averager_unit
    import pfda_pkg::*;
#(
    parameter int MAX_PAIRS = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CLK_W-1:0]       i_cfg_wdata,     // system_clock_hz
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // high_count_raw, low_count_raw
    input  logic                   s_axis_tlast,    // last_pair
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,    // avg_freq_q8, avg_duty_q16,
                                                    // pairs_counted, zero fill
    output logic                   m_axis_tuser     // no_cycles
);

    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int FSW = FREQ_Q + CW;
    localparam int DSW = DUTY_Q + CW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAIRS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_FREQ,
        OP_DUTY,
        OP_AVG_FREQ,
        OP_AVG_DUTY
    } t_op;

    t_state               r_state;
    t_op                  r_op;
    logic [CLK_W-1:0]     r_clk_hz;
    logic [HIGH_W-1:0]    r_high;
    logic [PER_W-1:0]     r_period;
    logic                 r_last;
    logic [FSW-1:0]       r_freq_sum;
    logic [DSW-1:0]       r_duty_sum;
    logic [CW-1:0]        r_count;
    logic [FREQ_Q-1:0]    r_avg_freq;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                 r_out_user;

    logic [PER_W-1:0]     w_period;
    logic [H100_W-1:0]    w_h100;
    logic [PAIRS_W+CW-1:0] w_cnt_ext;
    logic                 w_out_load;
    t_div_req             w_req;
    t_div_rsp             w_rsp;

    // Cycle counts are twice the complemented raw words.
    assign w_period = {1'b0, ~s_axis_tdata[RAW_W-1:0], 1'b0}
                    + {1'b0, ~s_axis_tdata[2*RAW_W-1:RAW_W], 1'b0};

    // high * 100 as three shifted terms (64 + 32 + 4).
    assign w_h100 = {1'b0, r_high, 6'b0} + {2'b0, r_high, 5'b0} + {5'b0, r_high, 2'b0};

    assign w_cnt_ext = {{PAIRS_W{1'b0}}, r_count};

    // The output register takes a new beat when it is empty or being drained.
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_req.start = (r_state == S_DIV_GO);
        case (r_op)
            OP_FREQ: begin
                w_req.steps = STEP_W'(FREQ_Q);
                w_req.rem   = {{(REM_W-1){1'b0}}, r_clk_hz[CLK_W-1]};
                w_req.num   = {r_clk_hz[CLK_W-2:0], 8'b0};
                w_req.div   = r_period;
            end
            OP_DUTY: begin
                // Numerator is high * 100 * 65536; quotient fits in 23 bits.
                w_req.steps = STEP_W'(DUTY_Q);
                w_req.rem   = REM_W'(w_h100[H100_W-1:7]);
                w_req.num   = {w_h100[6:0], 30'b0};
                w_req.div   = r_period;
            end
            OP_AVG_FREQ: begin
                w_req.steps = STEP_W'(FREQ_Q);
                w_req.rem   = {{(REM_W-CW){1'b0}}, r_freq_sum[FSW-1 -: CW]};
                w_req.num   = r_freq_sum[FREQ_Q-1:0];
                w_req.div   = {{(REM_W-CW){1'b0}}, r_count};
            end
            default: begin
                w_req.steps = STEP_W'(DUTY_Q);
                w_req.rem   = {{(REM_W-CW){1'b0}}, r_duty_sum[DSW-1 -: CW]};
                w_req.num   = {r_duty_sum[DUTY_Q-1:0], 14'b0};
                w_req.div   = {{(REM_W-CW){1'b0}}, r_count};
            end
        endcase
    end

    pfda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FREQ;
            r_clk_hz    <= CLK_RESET;
            r_freq_sum  <= '0;
            r_duty_sum  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_high   <= {~s_axis_tdata[RAW_W-1:0], 1'b0};
                        r_period <= w_period;
                        r_last   <= s_axis_tlast;
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_period != '0 && r_count < MAX_CNT) begin
                        r_op    <= OP_FREQ;
                        r_state <= S_DIV_GO;
                    end else if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_count == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= OP_AVG_FREQ;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        case (r_op)
                            OP_FREQ: begin
                                r_freq_sum <= r_freq_sum + FSW'(w_rsp.quot);
                                r_op       <= OP_DUTY;
                                r_state    <= S_DIV_GO;
                            end
                            OP_DUTY: begin
                                r_duty_sum <= r_duty_sum + DSW'(w_rsp.quot[DUTY_Q-1:0]);
                                r_count    <= r_count + 1'b1;
                                if (r_last) begin
                                    r_op    <= OP_AVG_FREQ;
                                    r_state <= S_DIV_GO;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            OP_AVG_FREQ: begin
                                r_avg_freq <= w_rsp.quot[FREQ_Q-1:0];
                                r_op       <= OP_AVG_DUTY;
                                r_state    <= S_DIV_GO;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    // The duty average still sits in the divider's quotient.
                    if (w_out_load) begin
                        if (r_count == '0) begin
                            r_out_data <= '0;
                            r_out_user <= 1'b1;
                        end else begin
                            r_out_data <= {2'b00, w_cnt_ext[PAIRS_W-1:0],
                                           w_rsp.quot[DUTY_Q-1:0], r_avg_freq};
                            r_out_user <= 1'b0;
                        end
                        r_freq_sum <= '0;
                        r_duty_sum <= '0;
                        r_count    <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_rsp.busy)
        else $error("divider busy while the sequencer is idle");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("pair count beyond limit");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_no_cycles_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
        else $error("no-cycles beat carries nonzero averages");

endmodule

FILE: dv/tb_pwm_freq_duty_averager_unit.sv
// ----------------------------------------------------------------------------
// tb_pwm_freq_duty_averager_unit
// Self-checking testbench for the PWM frequency and duty averager. Capture
// pairs go in on the slave stream, and each tlast beat is expected to return
// one average beat. A predictor inside the bench keeps its own running sums.
// A short table of directed pairs comes first, followed by randomized capture
// runs under several clock settings, with random idling on both streams, one
// long back-pressure stretch, and one run long enough to hit the pair limit.
// ----------------------------------------------------------------------------
module tb_pwm_freq_duty_averager_unit;
    import pfda_pkg::*;

    localparam int MAX_PAIRS_TB = 512;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE_CYC   = 200;
    localparam int PHASE_PAIRS  = 22;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_ROWS     = 15;
    localparam int DUTY_LSB     = FREQ_Q;
    localparam int PAIRS_LSB    = FREQ_Q + DUTY_Q;
    localparam int FILL_LSB     = PAIRS_LSB + PAIRS_W;
    localparam logic [RAW_W-1:0] ALL_ONES = '1;
    localparam bit [63:0] DUTY_SCALE = 64'd6553600;  // 100 percent in Q16

    typedef struct packed {
        logic [FREQ_Q-1:0]  freq_q8;
        logic [DUTY_Q-1:0]  duty_q16;
        logic [PAIRS_W-1:0] pairs;
        logic               no_cycles;
    } t_avg;

    typedef struct packed {
        logic [RAW_W-1:0] high_raw;
        logic [RAW_W-1:0] low_raw;
        logic             last;
        logic             typed;
        t_avg             want;
    } t_pair_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CLK_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // high_count_raw, low_count_raw
    logic                   s_axis_tlast  = 1'b0; // last_pair
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // avg_freq_q8, avg_duty_q16,
                                                  // pairs_counted, zero fill
    logic                   m_axis_tuser;         // no_cycles

    // Predictor state.
    logic [CLK_W-1:0] clk_hz = CLK_RESET;
    bit [63:0]        freq_acc = '0;
    bit [63:0]        duty_acc = '0;
    int unsigned      pair_cnt = 0;
    t_avg             avg_q[$];

    // Run control and bookkeeping.
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit hold_toggle = 1'b0;
    int err_cnt      = 0;
    int pairs_sent   = 0;
    int runs_sent    = 0;
    int limit_runs   = 0;
    int results_seen = 0;
    int empty_seen   = 0;

    pwm_freq_duty_averager_unit #(
        .MAX_PAIRS(MAX_PAIRS_TB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Folds one capture pair into the running sums; returns 1 with the
    // average when the pair closes a run.
    function automatic bit accumulate_pair(input logic [RAW_W-1:0] high_raw,
                                           input logic [RAW_W-1:0] low_raw,
                                           input bit last, output t_avg avg);
        bit [63:0] high_cyc;
        bit [63:0] period;
        high_cyc = {31'b0, ~high_raw, 1'b0};
        period   = high_cyc + {31'b0, ~low_raw, 1'b0};
        avg      = '0;
        if (period != 0 && pair_cnt < MAX_PAIRS_TB) begin
            freq_acc += ({34'b0, clk_hz} << 8) / period;
            duty_acc += (high_cyc * DUTY_SCALE) / period;
            pair_cnt++;
        end
        if (!last)
            return 1'b0;
        if (pair_cnt == 0) begin
            avg.no_cycles = 1'b1;
        end else begin
            avg.freq_q8  = FREQ_Q'(freq_acc / pair_cnt);
            avg.duty_q16 = DUTY_Q'(duty_acc / pair_cnt);
            avg.pairs    = PAIRS_W'(pair_cnt);
        end
        freq_acc = '0;
        duty_acc = '0;
        pair_cnt = 0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic check_average();
        t_avg want;
        if (avg_q.size() == 0) begin
            $error("average beat with nothing expected: tdata %h tuser %b",
                   m_axis_tdata, m_axis_tuser);
            err_cnt++;
            return;
        end
        want = avg_q.pop_front();
        results_seen++;
        if (m_axis_tuser)
            empty_seen++;
        check_field("avg_freq_q8", want.freq_q8, m_axis_tdata[DUTY_LSB-1:0]);
        check_field("avg_duty_q16", want.duty_q16, m_axis_tdata[PAIRS_LSB-1:DUTY_LSB]);
        check_field("pairs_counted", want.pairs, m_axis_tdata[FILL_LSB-1:PAIRS_LSB]);
        check_field("no_cycles", want.no_cycles, m_axis_tuser);
        check_field("zero fill", 0, m_axis_tdata[OUT_TDATA_W-1:FILL_LSB]);
    endtask

    // Receiver: checks at the rising edge, decides tready at the falling edge.
    initial begin
        bit hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                check_average();
            @(negedge i_clk);
            if (hold_seen != hold_toggle) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Offers one pair from a falling edge on, after any random idling, and returns at the
    // rising edge that accepts it. The pair is predicted on acceptance.
    task automatic send_pair(input logic [RAW_W-1:0] high_raw,
                             input logic [RAW_W-1:0] low_raw, input bit last,
                             input bit typed, input t_avg typed_want);
        t_avg avg;
        @(negedge i_clk);
        if (tx_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {low_raw, high_raw};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pairs_sent++;
        if (last)
            runs_sent++;
        if (accumulate_pair(high_raw, low_raw, last, avg))
            avg_q.push_back(typed ? typed_want : avg);
    endtask

    task automatic bus_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (avg_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Pairs without tlast give no beat, so the block may still be dividing
    // after the last average is out; give it time before touching the clock.
    task automatic set_clock_hz(input logic [CLK_W-1:0] value);
        bus_quiet();
        wait_drain();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        clk_hz = value;
    endtask

    // Most captures are close to the counter's start value, as on real inputs.
    function automatic logic [RAW_W-1:0] pick_raw();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return ALL_ONES - $urandom_range(0, 5000);
        if (sel < 70)
            return ALL_ONES - $urandom_range(0, 32'h00FF_FFFF);
        if (sel < 80)
            return ALL_ONES;
        if (sel < 85)
            return '0;
        return $urandom;
    endfunction

    task automatic send_run(input int len);
        logic [RAW_W-1:0] high_raw;
        logic [RAW_W-1:0] low_raw;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                high_raw = ALL_ONES;
                low_raw  = ALL_ONES;
            end else begin
                high_raw = pick_raw();
                low_raw  = pick_raw();
            end
            send_pair(high_raw, low_raw, i == len - 1, 1'b0, '0);
        end
    endtask

    // Every pair here has a nonzero period, so the count surely saturates.
    task automatic send_limit_run(input int extra);
        logic [RAW_W-1:0] high_raw;
        logic [RAW_W-1:0] low_raw;
        int               len;
        len = MAX_PAIRS_TB + extra;
        for (int i = 0; i < len; i++) begin
            high_raw = pick_raw();
            low_raw  = pick_raw();
            if (high_raw == ALL_ONES && low_raw == ALL_ONES)
                low_raw = '0;
            send_pair(high_raw, low_raw, i == len - 1, 1'b0, '0);
        end
    endtask

    // A run made only of zero-period pairs counts nothing.
    task automatic send_empty_run();
        int len;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
            send_pair(ALL_ONES, ALL_ONES, i == len - 1, 1'b0, '0);
    endtask

    initial begin
        t_pair_row        rows [NUM_ROWS];
        logic [CLK_W-1:0] clk_plan [NUM_PHASES];
        int               phase_start;

        rows = '{
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{37'd0, 23'd0, 10'd0, 1'b1}},
            '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b1,
              '{37'd19200000000, 23'd6553600, 10'd1, 1'b0}},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 1'b1,
              '{37'd19200000000, 23'd0, 10'd1, 1'b0}},
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{37'd2, 23'd3276800, 10'd1, 1'b0}},
            '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, '{37'd4, 23'd6553600, 10'd1, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, '{37'd4, 23'd0, 10'd1, 1'b0}},
            '{32'hFFFF_FF00, 32'hFFFF_FF00, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFF0, 32'hFFFF_FFE0, 1'b1, 1'b0, '0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
            '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 1'b0, '0},
            '{32'h1234_5678, 32'hFEDC_BA98, 1'b1, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{37'd0, 23'd0, 10'd0, 1'b1}}
        };
        clk_plan = '{30'd1, 30'd1000000000, 30'd0, 30'h3FFF_FFFF,
                     CLK_W'($urandom_range(1, 1000000000)), CLK_RESET};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs run at the clock setting left by reset.
        foreach (rows[i])
            send_pair(rows[i].high_raw, rows[i].low_raw, rows[i].last,
                      rows[i].typed, rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_clock_hz(clk_plan[ph]);
            tx_idle_on  = (ph != 3);
            rx_idle_on  = (ph != 3);
            phase_start = pairs_sent;
            if (ph == 1) begin
                send_limit_run($urandom_range(2, 6));
                limit_runs++;
            end
            if (ph == 2) begin
                // Stall the output long enough that the input backs up.
                hold_toggle = ~hold_toggle;
                repeat (12) send_run(1);
            end
            while (pairs_sent - phase_start < PHASE_PAIRS) begin
                if ($urandom_range(0, 99) < 85)
                    send_run($urandom_range(1, 8));
                else
                    send_empty_run();
            end
        end

        bus_quiet();
        wait_drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (avg_q.size() != 0) begin
            $error("%0d averages never arrived", avg_q.size());
            err_cnt++;
        end

        $display("Sent %0d capture pairs in %0d runs over %0d clock settings, %0d past the limit.",
                 pairs_sent, runs_sent, NUM_PHASES + 1, limit_runs);
        $display("Checked %0d averages, %0d with no cycles; %0d mismatches.",
                 results_seen, empty_seen, err_cnt);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
